// ----- src/cpbd_pkg.sv -----
`default_nettype none
package cpbd_pkg;

  localparam int HISTORY_DEPTH = 6;
  localparam int SAMPLE_BITS = 12;

  localparam int PCT_W = 7;
  localparam int CMAX_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 7;

  // Thresholds are compared as 100 * difference against baseline * percent,
  // which matches floor(baseline * percent / 100) exactly.
  localparam int PCT_SCALE = 100;
  localparam int CMP_W = SAMPLE_BITS + PCT_W;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(HISTORY_DEPTH);

  // Average by reciprocal multiplication, exact over the whole sum range.
  localparam int DIV_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int DIV_PROD_W = SUM_W + DIV_SHIFT;
  localparam logic [DIV_SHIFT-1:0] DIV_RECIP =
    DIV_SHIFT'((2 ** DIV_SHIFT + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

  localparam logic [PCT_W-1:0] TRIGGER_PCT_RST = PCT_W'(5);
  localparam logic [PCT_W-1:0] FLOOR_PCT_RST = PCT_W'(30);
  localparam logic [PCT_W-1:0] CONFIRM_PCT_RST = PCT_W'(4);
  localparam logic [PCT_W-1:0] NOISE_PCT_RST = PCT_W'(8);
  localparam logic [CMAX_W-1:0] CONFIRM_MAX_RST = CMAX_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_PCT = 3'd0,
    CFG_FLOOR_PCT = 3'd1,
    CFG_CONFIRM_PCT = 3'd2,
    CFG_NOISE_PCT = 3'd3,
    CFG_CONFIRM_MAX = 3'd4
  } cfg_reg_t;

endpackage
`default_nettype wire

// ----- src/cpbd_if.sv -----
`default_nettype none
interface cpbd_sample_if;
  logic valid;
  logic ready;
  logic [cpbd_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface cpbd_result_if;
  logic valid;
  logic ready;
  logic decision_valid;
  logic card_detected;
  logic card_active;
  logic [cpbd_pkg::SAMPLE_BITS-1:0] baseline;
  logic confirming;

  modport source (
    output valid, output decision_valid, output card_detected,
    output card_active, output baseline, output confirming, input ready
  );
  modport sink (
    input valid, input decision_valid, input card_detected,
    input card_active, input baseline, input confirming, output ready
  );
endinterface

interface cpbd_cfg_if;
  logic valid;
  logic ready;
  logic [cpbd_pkg::CFG_IDX_W-1:0] index;
  logic [cpbd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/card_presence_baseline_detector_unit.sv -----
`default_nettype none
// Card presence detector on a stream of antenna ADC levels. One result word
// leaves for every sample word taken. The first HISTORY_DEPTH samples after
// reset only calibrate: they fill the history and set the baseline to their
// truncated average, and their results carry no decision. After that each
// sample is checked against the baseline; a large drop opens a confirmation
// of up to confirm_max further samples, and decision_valid marks the sample
// that closes a decision. A sample is taken every cycle while the result side
// keeps up, and it waits in the input register while combinational arithmetic
// (four baseline-by-percent products, the running history sum and a
// reciprocal multiply for the new average) feeds the result register. A
// stalled result register holds the input register, so at most two words are
// in flight. Configuration writes are always taken and should only be made
// while no sample is in flight.
module card_presence_baseline_detector_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  cpbd_sample_if.sink       samples,
  cpbd_result_if.source     results,
  cpbd_cfg_if.sink          cfg
);

  // Configuration registers
  logic [cpbd_pkg::PCT_W-1:0] trigger_pct;
  logic [cpbd_pkg::PCT_W-1:0] floor_pct;
  logic [cpbd_pkg::PCT_W-1:0] confirm_pct;
  logic [cpbd_pkg::PCT_W-1:0] noise_pct;
  logic [cpbd_pkg::CMAX_W-1:0] confirm_max;

  // Input stage
  logic in_vld;
  logic [cpbd_pkg::SAMPLE_BITS-1:0] in_sample;

  // Output stage
  logic out_vld;

  // Detector state
  logic [cpbd_pkg::SAMPLE_BITS-1:0] history [cpbd_pkg::HISTORY_DEPTH];
  logic [cpbd_pkg::SUM_W-1:0] hist_sum;
  logic [cpbd_pkg::SAMPLE_BITS-1:0] env_baseline;
  logic active_flag;
  logic [cpbd_pkg::CNT_W-1:0] calib_count;
  logic in_confirm;
  logic [cpbd_pkg::CMAX_W-1:0] confirm_index;
  logic verdict_so_far;

  logic active_flag_next;
  logic [cpbd_pkg::CNT_W-1:0] calib_count_next;
  logic in_confirm_next;
  logic [cpbd_pkg::CMAX_W-1:0] confirm_index_next;
  logic verdict_so_far_next;
  logic [cpbd_pkg::SUM_W-1:0] hist_sum_next;
  logic [cpbd_pkg::SAMPLE_BITS-1:0] env_baseline_next;

  logic advance;
  logic calib_done;
  logic below;
  logic [cpbd_pkg::SAMPLE_BITS-1:0] diff;
  logic [cpbd_pkg::CMP_W-1:0] diff_x100;
  logic [cpbd_pkg::CMP_W-1:0] sample_x100;
  logic [cpbd_pkg::CMP_W-1:0] trig_thr;
  logic [cpbd_pkg::CMP_W-1:0] floor_thr;
  logic [cpbd_pkg::CMP_W-1:0] confirm_thr;
  logic [cpbd_pkg::CMP_W-1:0] noise_thr;
  logic [cpbd_pkg::CMAX_W-1:0] index_inc;
  logic push;
  logic base_load;
  logic [cpbd_pkg::SAMPLE_BITS-1:0] push_sample;
  logic [cpbd_pkg::SAMPLE_BITS-1:0] drop_sample;
  logic [cpbd_pkg::DIV_PROD_W-1:0] avg_prod;
  logic dec_valid;
  logic dec_detected;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_pct <= cpbd_pkg::TRIGGER_PCT_RST;
      floor_pct <= cpbd_pkg::FLOOR_PCT_RST;
      confirm_pct <= cpbd_pkg::CONFIRM_PCT_RST;
      noise_pct <= cpbd_pkg::NOISE_PCT_RST;
      confirm_max <= cpbd_pkg::CONFIRM_MAX_RST;
    end else if (cfg.valid) begin
      case (cpbd_pkg::cfg_reg_t'(cfg.index))
        cpbd_pkg::CFG_TRIGGER_PCT: trigger_pct <= cfg.data;
        cpbd_pkg::CFG_FLOOR_PCT: floor_pct <= cfg.data;
        cpbd_pkg::CFG_CONFIRM_PCT: confirm_pct <= cfg.data;
        cpbd_pkg::CFG_NOISE_PCT: noise_pct <= cfg.data;
        cpbd_pkg::CFG_CONFIRM_MAX: confirm_max <= cfg.data[cpbd_pkg::CMAX_W-1:0];
        default: ;
      endcase
    end
  end

  // A word moves from the input register to the result register whenever
  // the result register is empty or being drained.
  assign advance = in_vld && (!out_vld || results.ready);
  assign samples.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_sample <= samples.sample;
    end
  end

  assign calib_done = (calib_count == cpbd_pkg::CNT_W'(cpbd_pkg::HISTORY_DEPTH));
  assign below = (in_sample < env_baseline);
  assign diff = below ? (env_baseline - in_sample) : (in_sample - env_baseline);
  assign diff_x100 = cpbd_pkg::CMP_W'(diff) * cpbd_pkg::CMP_W'(cpbd_pkg::PCT_SCALE);
  assign sample_x100 = cpbd_pkg::CMP_W'(in_sample) * cpbd_pkg::CMP_W'(cpbd_pkg::PCT_SCALE);
  assign trig_thr = cpbd_pkg::CMP_W'(env_baseline) * cpbd_pkg::CMP_W'(trigger_pct);
  assign floor_thr = cpbd_pkg::CMP_W'(env_baseline) * cpbd_pkg::CMP_W'(floor_pct);
  assign confirm_thr = cpbd_pkg::CMP_W'(env_baseline) * cpbd_pkg::CMP_W'(confirm_pct);
  assign noise_thr = cpbd_pkg::CMP_W'(env_baseline) * cpbd_pkg::CMP_W'(noise_pct);
  assign index_inc = confirm_index + cpbd_pkg::CMAX_W'(1);

  always_comb begin
    active_flag_next = active_flag;
    calib_count_next = calib_count;
    in_confirm_next = in_confirm;
    confirm_index_next = confirm_index;
    verdict_so_far_next = verdict_so_far;
    push = 1'b0;
    base_load = 1'b0;
    push_sample = in_sample;
    dec_valid = 1'b0;
    dec_detected = 1'b0;

    if (!calib_done) begin
      calib_count_next = calib_count + cpbd_pkg::CNT_W'(1);
      push = 1'b1;
      base_load = (calib_count == cpbd_pkg::CNT_W'(cpbd_pkg::HISTORY_DEPTH - 1));
    end else if (in_confirm) begin
      if (!below) begin
        in_confirm_next = 1'b0;
        dec_valid = 1'b1;
        dec_detected = verdict_so_far;
      end else if (diff_x100 > confirm_thr) begin
        active_flag_next = 1'b1;
        verdict_so_far_next = 1'b1;
        confirm_index_next = index_inc;
        if (index_inc >= confirm_max) begin
          in_confirm_next = 1'b0;
          dec_valid = 1'b1;
          dec_detected = 1'b1;
        end
      end else begin
        active_flag_next = 1'b0;
        verdict_so_far_next = 1'b0;
        in_confirm_next = 1'b0;
        dec_valid = 1'b1;
      end
    end else if (below) begin
      if (diff_x100 <= trig_thr) begin
        active_flag_next = 1'b0;
        push = 1'b1;
        base_load = 1'b1;
        dec_valid = 1'b1;
      end else if (sample_x100 > floor_thr && confirm_max != '0) begin
        in_confirm_next = 1'b1;
        confirm_index_next = '0;
        verdict_so_far_next = 1'b0;
      end else begin
        dec_valid = 1'b1;
      end
    end else begin
      // A rise beyond the noise band is clipped to the baseline.
      if (diff_x100 > noise_thr) begin
        push_sample = env_baseline;
      end
      push = 1'b1;
      base_load = 1'b1;
      dec_valid = 1'b1;
    end
  end

  // The oldest entry holds no calibration sample (the history has no reset)
  // until calibration has filled it, so it is only subtracted once calibration is done.
  assign drop_sample = calib_done ? history[0] : '0;

  always_comb begin
    hist_sum_next = hist_sum;
    if (push) begin
      hist_sum_next = hist_sum + cpbd_pkg::SUM_W'(push_sample) - cpbd_pkg::SUM_W'(drop_sample);
    end
  end

  assign avg_prod = cpbd_pkg::DIV_PROD_W'(hist_sum_next)
                  * cpbd_pkg::DIV_PROD_W'(cpbd_pkg::DIV_RECIP);
  assign env_baseline_next = base_load
                           ? avg_prod[cpbd_pkg::DIV_SHIFT +: cpbd_pkg::SAMPLE_BITS]
                           : env_baseline;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_sum <= '0;
      env_baseline <= '0;
      active_flag <= 1'b0;
      calib_count <= '0;
      in_confirm <= 1'b0;
      confirm_index <= '0;
      verdict_so_far <= 1'b0;
    end else if (advance) begin
      hist_sum <= hist_sum_next;
      env_baseline <= env_baseline_next;
      active_flag <= active_flag_next;
      calib_count <= calib_count_next;
      in_confirm <= in_confirm_next;
      confirm_index <= confirm_index_next;
      verdict_so_far <= verdict_so_far_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push) begin
      for (int i = 0; i < cpbd_pkg::HISTORY_DEPTH - 1; i++) begin
        history[i] <= history[i+1];
      end
      history[cpbd_pkg::HISTORY_DEPTH-1] <= push_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.decision_valid <= dec_valid;
      results.card_detected <= dec_valid && dec_detected;
      results.card_active <= active_flag_next;
      results.baseline <= env_baseline_next;
      results.confirming <= in_confirm_next;
    end
  end

  assign results.valid = out_vld;

  // Confirmation can only be open once calibration has finished.
  a_confirm_after_calib: assert property (@(posedge clk) disable iff (rst)
    in_confirm |-> calib_done)
    else $error("confirmation open during calibration");

  // The baseline is only set by the average at the end of calibration.
  a_baseline_zero_in_calib: assert property (@(posedge clk) disable iff (rst)
    !calib_done |-> env_baseline == '0)
    else $error("baseline changed during calibration");

  // Within a confirmation the verdict is set exactly when a sample has counted.
  a_verdict_tracks_index: assert property (@(posedge clk) disable iff (rst)
    in_confirm |-> verdict_so_far == (confirm_index != '0))
    else $error("confirmation verdict and index disagree");

  // A present verdict is only reported on a completed decision.
  a_detect_needs_decision: assert property (@(posedge clk) disable iff (rst)
    out_vld && results.card_detected |-> results.decision_valid)
    else $error("card reported without a decision");

  // Every word that moves on leaves a result behind.
  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_vld)
    else $error("result register empty after a word moved on");

endmodule
`default_nettype wire
